/* hw/rtl/rrwt_pkg.sv */
// ----------------------------------------------------------------------------
// rrwt_pkg: shared definitions for the round-robin wait-time block
// Defaults, field widths, saturation limits, register indexes and sequencer
// codes used across the block.
// ----------------------------------------------------------------------------
package rrwt_pkg;

   localparam int MAX_PROCS_DEF  = 16;
   localparam int BURST_BITS_DEF = 16;

   localparam int SLICE_W   = 16;
   localparam int TIME_W    = 20;
   localparam int SUM_W     = 24;
   localparam int INDEX_W   = 4;

   localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd4;
   localparam logic [TIME_W-1:0]  TIME_MAX    = '1;
   localparam logic [SUM_W-1:0]   SUM_MAX     = '1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = CSR_ADDR_W - 2;

   localparam logic [CSR_INDEX_W-1:0] REG_TIME_SLICE = 1'd0;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RUN_RD,
      ST_RUN_CMP,
      ST_RUN_ADD,
      ST_RUN_WAIT,
      ST_OUT_RD,
      ST_OUT_TURN,
      ST_OUT_SW,
      ST_OUT_ST,
      ST_OUT_HOLD
   } rrwt_state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } rrwt_alu_op_type;

endpackage

/* hw/rtl/rrwt_if.sv */
// ----------------------------------------------------------------------------
// rrwt_req_if / rrwt_rsp_if: request and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface rrwt_req_if #(
   parameter int BURST_BITS = 16
);
   logic                  valid;
   logic                  ready;
   logic [BURST_BITS-1:0] burst_len;
   logic                  last_process;

   modport source (output valid, output burst_len, output last_process, input ready);
   modport sink   (input valid, input burst_len, input last_process, output ready);
endinterface

interface rrwt_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  process_index;
   logic [19:0] waiting_time;
   logic [19:0] turnaround_time;
   logic [23:0] total_waiting;
   logic [23:0] total_turnaround;
   logic        last_result;

   modport source (output valid, output process_index, output waiting_time,
                   output turnaround_time, output total_waiting,
                   output total_turnaround, output last_result, input ready);
   modport sink   (input valid, input process_index, input waiting_time,
                   input turnaround_time, input total_waiting,
                   input total_turnaround, input last_result, output ready);
endinterface

/* hw/rtl/rrwt_csr.sv */
// ----------------------------------------------------------------------------
// rrwt_csr: configuration register file
// APB-style write and read of the time slice register.
// ----------------------------------------------------------------------------
module rrwt_csr
   import rrwt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [SLICE_W-1:0]    time_slice
);

   logic [SLICE_W-1:0]     slice_ff;
   logic [SLICE_W-1:0]     slice_in;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic                   wr_slice;

   assign reg_index = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_slice  = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (reg_index == REG_TIME_SLICE);

   always_comb begin
      slice_in = slice_ff;
      if (wr_slice) begin
         slice_in = csr_pwdata[SLICE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_ff <= SLICE_RESET;
      end else begin
         slice_ff <= slice_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_TIME_SLICE) begin
         csr_prdata = CSR_DATA_W'(slice_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign time_slice = slice_ff;

endmodule

/* hw/rtl/rrwt_table.sv */
// ----------------------------------------------------------------------------
// rrwt_table: process table memory
// One write port and one registered read port holding burst, remaining work
// and waiting time per process.
// ----------------------------------------------------------------------------
module rrwt_table
   import rrwt_pkg::*;
#(
   parameter int DEPTH  = MAX_PROCS_DEF,
   parameter int WIDTH  = 56,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rrwt_alu.sv */
// ----------------------------------------------------------------------------
// rrwt_alu: shared adder/subtractor
// Single add or subtract shared by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module rrwt_alu
   import rrwt_pkg::*;
#(
   parameter int WIDTH = 25
) (
   input  rrwt_alu_op_type  op,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] result
);

   always_comb begin
      unique case (op)
         ALU_ADD: result = a + b;
         ALU_SUB: result = a - b;
         default: result = a + b;
      endcase
   end

endmodule

/* hw/rtl/rrwt_seq.sv */
// ----------------------------------------------------------------------------
// rrwt_seq: load, time-slice and report sequencer
// Loads bursts into the table, walks round-robin passes through the shared
// ALU, then reports one result per process with saturating totals.
// ----------------------------------------------------------------------------
module rrwt_seq
   import rrwt_pkg::*;
#(
   parameter int MAX_PROCS  = MAX_PROCS_DEF,
   parameter int BURST_BITS = BURST_BITS_DEF,
   parameter int IDX_W      = 4,
   parameter int CLK_W      = 20,
   parameter int ENTRY_W    = 52,
   parameter int ALU_W      = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [SLICE_W-1:0] time_slice,
   rrwt_req_if.sink           req,
   rrwt_rsp_if.source         rsp,
   output logic               tbl_wr_en,
   output logic [IDX_W-1:0]   tbl_wr_addr,
   output logic [ENTRY_W-1:0] tbl_wr_data,
   output logic               tbl_rd_en,
   output logic [IDX_W-1:0]   tbl_rd_addr,
   input  logic [ENTRY_W-1:0] tbl_rd_data,
   output rrwt_alu_op_type    alu_op,
   output logic [ALU_W-1:0]   alu_a,
   output logic [ALU_W-1:0]   alu_b,
   input  logic [ALU_W-1:0]   alu_result
);

   localparam int CNT_W = $clog2(MAX_PROCS + 1);

   rrwt_state_type        state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  finish_ff, finish_in;
   logic [BURST_BITS-1:0] addend_ff, addend_in;
   logic [CLK_W-1:0]      clock_ff, clock_in;
   logic [TIME_W-1:0]     wout_ff, wout_in;
   logic [TIME_W-1:0]     turn_ff, turn_in;
   logic [SUM_W-1:0]      sum_wait_ff, sum_wait_in;
   logic [SUM_W-1:0]      sum_turn_ff, sum_turn_in;

   logic [BURST_BITS-1:0] ent_burst;
   logic [BURST_BITS-1:0] ent_rem;
   logic [CLK_W-1:0]      ent_wait;
   logic [SLICE_W-1:0]    quantum;
   logic                  last_idx;
   logic                  rem_zero;
   logic                  rem_gt;
   logic                  accept;
   logic                  room;
   logic [ALU_W-1:0]      wait_wide;
   logic [TIME_W-1:0]     alu_time_sat;
   logic [TIME_W-1:0]     wait_time_sat;
   logic [SUM_W-1:0]      alu_sum_sat;

   assign ent_burst = tbl_rd_data[ENTRY_W-1 -: BURST_BITS];
   assign ent_rem   = tbl_rd_data[CLK_W+BURST_BITS-1 -: BURST_BITS];
   assign ent_wait  = tbl_rd_data[CLK_W-1:0];

   assign quantum   = (time_slice == '0) ? SLICE_W'(1) : time_slice;
   assign last_idx  = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));
   assign rem_zero  = (ent_rem == '0);
   assign rem_gt    = !alu_result[ALU_W-1] && (alu_result != '0);
   assign accept    = req.valid && req.ready;
   assign room      = (count_ff < CNT_W'(MAX_PROCS));

   assign wait_wide     = ALU_W'(ent_wait);
   assign alu_time_sat  = (alu_result > ALU_W'(TIME_MAX)) ? TIME_MAX
                          : alu_result[TIME_W-1:0];
   assign wait_time_sat = (wait_wide > ALU_W'(TIME_MAX)) ? TIME_MAX
                          : wait_wide[TIME_W-1:0];
   assign alu_sum_sat   = (alu_result > ALU_W'(SUM_MAX)) ? SUM_MAX
                          : alu_result[SUM_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req.last_process) begin
               state_in = ST_RUN_RD;
            end
         end
         ST_RUN_RD: state_in = ST_RUN_CMP;
         ST_RUN_CMP: begin
            if (!rem_zero) begin
               state_in = ST_RUN_ADD;
            end else if (last_idx && !busy_ff) begin
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_RUN_RD;
            end
         end
         ST_RUN_ADD: begin
            if (finish_ff) begin
               state_in = ST_RUN_WAIT;
            end else if (last_idx && !busy_ff) begin
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_RUN_RD;
            end
         end
         ST_RUN_WAIT: begin
            if (last_idx && !busy_ff) begin
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_RUN_RD;
            end
         end
         ST_OUT_RD:   state_in = ST_OUT_TURN;
         ST_OUT_TURN: state_in = ST_OUT_SW;
         ST_OUT_SW:   state_in = ST_OUT_ST;
         ST_OUT_ST:   state_in = ST_OUT_HOLD;
         ST_OUT_HOLD: begin
            if (rsp.ready) begin
               state_in = last_idx ? ST_LOAD : ST_OUT_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath and memory control
   always_comb begin
      idx_in      = idx_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      finish_in   = finish_ff;
      addend_in   = addend_ff;
      clock_in    = clock_ff;
      wout_in     = wout_ff;
      turn_in     = turn_ff;
      sum_wait_in = sum_wait_ff;
      sum_turn_in = sum_turn_ff;
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = idx_ff;
      tbl_wr_data = {ent_burst, ent_rem, ent_wait};
      tbl_rd_en   = 1'b0;
      tbl_rd_addr = idx_ff;
      alu_op      = ALU_ADD;
      alu_a       = ALU_W'(clock_ff);
      alu_b       = ALU_W'(addend_ff);
      req.ready   = 1'b0;
      rsp.valid   = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            req.ready = 1'b1;
            if (accept) begin
               if (room) begin
                  tbl_wr_en   = 1'b1;
                  tbl_wr_addr = count_ff[IDX_W-1:0];
                  tbl_wr_data = {req.burst_len, req.burst_len, CLK_W'(0)};
                  count_in    = count_ff + CNT_W'(1);
               end
               if (req.last_process) begin
                  idx_in   = '0;
                  busy_in  = 1'b0;
                  clock_in = '0;
               end
            end
         end
         ST_RUN_RD: begin
            tbl_rd_en = 1'b1;
         end
         ST_RUN_CMP: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(ent_rem);
            alu_b  = ALU_W'(quantum);
            if (rem_zero) begin
               idx_in  = last_idx ? '0 : idx_ff + IDX_W'(1);
               busy_in = last_idx ? 1'b0 : busy_ff;
            end else begin
               busy_in = 1'b1;
               if (rem_gt) begin
                  tbl_wr_en   = 1'b1;
                  tbl_wr_data = {ent_burst, alu_result[BURST_BITS-1:0], ent_wait};
                  addend_in   = BURST_BITS'(quantum);
                  finish_in   = 1'b0;
               end else begin
                  addend_in = ent_rem;
                  finish_in = 1'b1;
               end
            end
         end
         ST_RUN_ADD: begin
            clock_in = alu_result[CLK_W-1:0];
            if (!finish_ff) begin
               idx_in  = last_idx ? '0 : idx_ff + IDX_W'(1);
               busy_in = last_idx ? 1'b0 : busy_ff;
            end
         end
         ST_RUN_WAIT: begin
            alu_op      = ALU_SUB;
            alu_a       = ALU_W'(clock_ff);
            alu_b       = ALU_W'(ent_burst);
            tbl_wr_en   = 1'b1;
            tbl_wr_data = {ent_burst, BURST_BITS'(0), alu_result[CLK_W-1:0]};
            idx_in      = last_idx ? '0 : idx_ff + IDX_W'(1);
            busy_in     = last_idx ? 1'b0 : busy_ff;
         end
         ST_OUT_RD: begin
            tbl_rd_en = 1'b1;
         end
         ST_OUT_TURN: begin
            alu_a   = ALU_W'(ent_burst);
            alu_b   = wait_wide;
            turn_in = alu_time_sat;
            wout_in = wait_time_sat;
         end
         ST_OUT_SW: begin
            alu_a       = ALU_W'(sum_wait_ff);
            alu_b       = ALU_W'(wout_ff);
            sum_wait_in = alu_sum_sat;
         end
         ST_OUT_ST: begin
            alu_a       = ALU_W'(sum_turn_ff);
            alu_b       = ALU_W'(turn_ff);
            sum_turn_in = alu_sum_sat;
         end
         ST_OUT_HOLD: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               if (last_idx) begin
                  count_in    = '0;
                  clock_in    = '0;
                  sum_wait_in = '0;
                  sum_turn_in = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         idx_ff      <= '0;
         count_ff    <= '0;
         busy_ff     <= 1'b0;
         finish_ff   <= 1'b0;
         clock_ff    <= '0;
         sum_wait_ff <= '0;
         sum_turn_ff <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         count_ff    <= count_in;
         busy_ff     <= busy_in;
         finish_ff   <= finish_in;
         clock_ff    <= clock_in;
         sum_wait_ff <= sum_wait_in;
         sum_turn_ff <= sum_turn_in;
      end
   end

   always_ff @(posedge clock) begin
      addend_ff <= addend_in;
      wout_ff   <= wout_in;
      turn_ff   <= turn_in;
   end

   assign rsp.process_index    = INDEX_W'(idx_ff);
   assign rsp.waiting_time     = wout_ff;
   assign rsp.turnaround_time  = turn_ff;
   assign rsp.total_waiting    = sum_wait_ff;
   assign rsp.total_turnaround = sum_turn_ff;
   assign rsp.last_result      = last_idx;

endmodule

/* hw/rtl/round_robin_wait_times.sv */
// ----------------------------------------------------------------------------
// round_robin_wait_times: round-robin waiting and turnaround times
// Send one request per process carrying its burst time; last_process marks
// the final one of a set. Loading accepts one request per cycle. A burst
// that arrives when the table already holds MAX_PROCS entries is dropped.
// After the final request the block stops taking requests and simulates
// round-robin time slicing with the quantum in register time_slice (0 acts
// as 1). Each pass visits every loaded process through one shared adder: a
// finished process is read and compared, a quantum slice also advances the
// clock, and a completing process also writes its waiting time. A pass that
// finds no work left ends the run. Results then leave in load order, one
// per process; each is offered after read, turnaround and two total steps
// and held stable until rsp.ready is high, and the next is not begun until
// it is taken. Totals saturate at their maximum. On the cycle after the last
// result the block has cleared the set and takes requests again. Reset
// empties the set, clears the totals and sets time_slice to 4. The table is
// written before it is read, so it needs no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_wait_times
   import rrwt_pkg::*;
#(
   parameter int MAX_PROCS  = MAX_PROCS_DEF,
   parameter int BURST_BITS = BURST_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rrwt_req_if.sink              req,
   rrwt_rsp_if.source            rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CLK_W   = BURST_BITS + $clog2(MAX_PROCS);
   localparam int ENTRY_W = 2 * BURST_BITS + CLK_W;
   localparam int ALU_W   = ((CLK_W > SUM_W) ? CLK_W : SUM_W) + 1;

   logic [SLICE_W-1:0] time_slice;
   logic               tbl_wr_en;
   logic [IDX_W-1:0]   tbl_wr_addr;
   logic [ENTRY_W-1:0] tbl_wr_data;
   logic               tbl_rd_en;
   logic [IDX_W-1:0]   tbl_rd_addr;
   logic [ENTRY_W-1:0] tbl_rd_data;
   rrwt_alu_op_type    alu_op;
   logic [ALU_W-1:0]   alu_a;
   logic [ALU_W-1:0]   alu_b;
   logic [ALU_W-1:0]   alu_result;

   rrwt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .time_slice  (time_slice)
   );

   rrwt_table #(
      .DEPTH  (MAX_PROCS),
      .WIDTH  (ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   rrwt_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_result)
   );

   rrwt_seq #(
      .MAX_PROCS  (MAX_PROCS),
      .BURST_BITS (BURST_BITS),
      .IDX_W      (IDX_W),
      .CLK_W      (CLK_W),
      .ENTRY_W    (ENTRY_W),
      .ALU_W      (ALU_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .time_slice  (time_slice),
      .req         (req),
      .rsp         (rsp),
      .tbl_wr_en   (tbl_wr_en),
      .tbl_wr_addr (tbl_wr_addr),
      .tbl_wr_data (tbl_wr_data),
      .tbl_rd_en   (tbl_rd_en),
      .tbl_rd_addr (tbl_rd_addr),
      .tbl_rd_data (tbl_rd_data),
      .alu_op      (alu_op),
      .alu_a       (alu_a),
      .alu_b       (alu_b),
      .alu_result  (alu_result)
   );

endmodule

/* verif/tb_round_robin_wait_times.sv */
// ----------------------------------------------------------------------------
// tb_round_robin_wait_times: self-checking bench for the round-robin block
// Loads sets of burst times through the request channel and checks every
// result against an in-bench scheduler that replays round-robin slicing.
// The run covers directed extremes, table overflow, a zero quantum and
// random sets under several quanta. Random gaps and stalls are applied on
// both channels, and one long result hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_round_robin_wait_times;
   import rrwt_pkg::*;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [TIME_W-1:0]  wait_ticks;
      logic [TIME_W-1:0]  turn_ticks;
      logic [SUM_W-1:0]   sum_wait;
      logic [SUM_W-1:0]   sum_turn;
      logic               closes_set;
   } rr_result_type;

   typedef struct packed {
      logic [BURST_BITS_DEF-1:0] burst;
      logic                      closes_set;
   } rr_request_type;

   localparam int CYCLE_LIMIT     = 1500000;
   localparam int PRESSURE_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 16;
   localparam logic [CSR_ADDR_W-1:0] SLICE_ADDR = {REG_TIME_SLICE, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rrwt_req_if #(.BURST_BITS(BURST_BITS_DEF)) req ();
   rrwt_rsp_if rsp ();

   round_robin_wait_times dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [BURST_BITS_DEF-1:0] burst_table [MAX_PROCS_DEF];
   int                        loaded_procs = 0;
   logic [SLICE_W-1:0]        slice_setting = SLICE_RESET;
   rr_result_type             expected_results[$];
   rr_request_type            pending_requests[$];

   int   errors        = 0;
   int   cycle_count   = 0;
   int   req_gap       = 0;
   int   rsp_gap       = 0;
   int   hold_left     = 0;
   bit   pressure_go   = 0;
   bit   pressure_done = 0;
   bit   idle_on       = 1;
   logic req_taken     = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic longint clip(input longint v, input longint top);
      return (v > top) ? top : v;
   endfunction

   task automatic schedule_set();
      longint        remaining [MAX_PROCS_DEF];
      longint        waits [MAX_PROCS_DEF];
      longint        quantum;
      longint        now;
      longint        wt;
      longint        tt;
      longint        sw;
      longint        st;
      bit            busy;
      rr_result_type r;
      quantum = (slice_setting == 0) ? 1 : slice_setting;
      now = 0;
      sw = 0;
      st = 0;
      for (int i = 0; i < loaded_procs; i++) begin
         remaining[i] = burst_table[i];
         waits[i] = 0;
      end
      busy = 1;
      while (busy) begin
         busy = 0;
         for (int i = 0; i < loaded_procs; i++) begin
            if (remaining[i] != 0) begin
               busy = 1;
               if (remaining[i] > quantum) begin
                  now += quantum;
                  remaining[i] -= quantum;
               end else begin
                  now += remaining[i];
                  waits[i] = now - burst_table[i];
                  remaining[i] = 0;
               end
            end
         end
      end
      for (int i = 0; i < loaded_procs; i++) begin
         wt = clip(waits[i], longint'(TIME_MAX));
         tt = clip(burst_table[i] + waits[i], longint'(TIME_MAX));
         sw = clip(sw + wt, longint'(SUM_MAX));
         st = clip(st + tt, longint'(SUM_MAX));
         r.index      = INDEX_W'(i);
         r.wait_ticks = TIME_W'(wt);
         r.turn_ticks = TIME_W'(tt);
         r.sum_wait   = SUM_W'(sw);
         r.sum_turn   = SUM_W'(st);
         r.closes_set = (i == loaded_procs - 1);
         expected_results.push_back(r);
      end
      loaded_procs = 0;
   endtask

   task absorb_request(input logic [BURST_BITS_DEF-1:0] burst, input logic closes);
      if (loaded_procs < MAX_PROCS_DEF) begin
         burst_table[loaded_procs] = burst;
         loaded_procs++;
      end
      if (closes) schedule_set();
   endtask

   task automatic queue_request(input int burst, input bit closes);
      rr_request_type r;
      r.burst      = BURST_BITS_DEF'(burst);
      r.closes_set = closes;
      pending_requests.push_back(r);
   endtask

   task automatic queue_set(input int count, input int top);
      int pick;
      int burst;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) burst = 0;
         else if (pick == 1) burst = top;
         else burst = $urandom_range(0, top);
         queue_request(burst, i == count - 1);
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req.valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_slice(input logic [SLICE_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SLICE_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      slice_setting = value;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[SLICE_W-1:0] !== value) begin
         errors++;
         $display("%0t: time_slice readback expected %0d actual %0d",
                  $time, value, csr_prdata[SLICE_W-1:0]);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin : drive_requests
      rr_request_type next_req;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req_taken) begin
         if (req_gap != 0) begin
            req_gap   <= req_gap - 1;
            req.valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            next_req = pending_requests.pop_front();
            req.valid        <= 1'b1;
            req.burst_len    <= next_req.burst;
            req.last_process <= next_req.closes_set;
            req_gap          <= pick_gap();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // long result hold-off
   always @(negedge clock) begin
      if (pressure_go && !pressure_done) begin
         hold_left     <= PRESSURE_CYCLES;
         pressure_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset || hold_left != 0) begin
         rsp.ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
         rsp_gap   <= pick_gap();
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin : watch_channels
      rr_result_type seen;
      rr_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req.valid && req.ready;
         if (req.valid && req.ready) absorb_request(req.burst_len, req.last_process);
         if (rsp.valid && rsp.ready) begin
            seen = {rsp.process_index, rsp.waiting_time, rsp.turnaround_time,
                    rsp.total_waiting, rsp.total_turnaround, rsp.last_result};
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result idx=%0d wait=%0d turn=%0d", $time,
                        seen.index, seen.wait_ticks, seen.turn_ticks);
            end else begin
               want = expected_results.pop_front();
               if (seen !== want) begin
                  errors++;
                  $display("%0t: expected idx=%0d wait=%0d turn=%0d sumw=%0d sumt=%0d last=%0b",
                           $time, want.index, want.wait_ticks, want.turn_ticks,
                           want.sum_wait, want.sum_turn, want.closes_set);
                  $display("%0t: actual   idx=%0d wait=%0d turn=%0d sumw=%0d sumt=%0d last=%0b",
                           $time, seen.index, seen.wait_ticks, seen.turn_ticks,
                           seen.sum_wait, seen.sum_turn, seen.closes_set);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[round_robin_wait_times] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int slice;
      int top;
      int queued;
      int count;
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.burst_len    = '0;
      req.last_process = 1'b0;
      rsp.ready        = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset quantum, a zero burst inside a set and alone
      queue_request(5, 0);
      queue_request(4, 0);
      queue_request(0, 0);
      queue_request(9, 1);
      queue_request(0, 1);
      wait_idle();

      // widest quantum, widest burst, overflowing table
      write_slice(16'hFFFF);
      queue_request(65535, 1);
      for (int i = 0; i < 17; i++) queue_request(65535, i == 16);
      wait_idle();

      // zero quantum acts as one
      write_slice(16'h0000);
      queue_request(3, 0);
      queue_request(0, 0);
      queue_request(5, 1);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: slice = 1;
            1: slice = $urandom_range(2, 9);
            2: slice = $urandom_range(10, 400);
            3: slice = $urandom_range(401, 65534);
            4: slice = 65535;
            default: slice = $urandom_range(1, 65535);
         endcase
         write_slice(SLICE_W'(slice));
         idle_on = (p != 1 && p != 4);
         if (p == 0) pressure_go = 1;
         top = (slice * 48 > 65535) ? 65535 : slice * 48;
         queued = 0;
         while (queued < 24) begin
            if ($urandom_range(0, 7) == 0) count = $urandom_range(17, 20);
            else count = $urandom_range(1, 16);
            queue_set(count, top);
            queued += count;
         end
         wait_idle();
      end

      if (errors == 0) begin
         $display("[round_robin_wait_times] OK");
      end else begin
         $display("[round_robin_wait_times] ERROR");
      end
      $finish;
   end

endmodule

/* round_robin_wait_times.f */
hw/rtl/rrwt_pkg.sv
hw/rtl/rrwt_if.sv
hw/rtl/rrwt_csr.sv
hw/rtl/rrwt_table.sv
hw/rtl/rrwt_alu.sv
hw/rtl/rrwt_seq.sv
hw/rtl/round_robin_wait_times.sv
verif/tb_round_robin_wait_times.sv
